>>> rtl/assert_macros.svh
// Assertion macros used by the hash engine top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

>>> rtl/sha_pkg.sv
// Types, constants and round functions of the SHA-512/384 engine.
package sha_pkg;
  typedef logic [63:0] word_t;

  typedef struct packed {
    logic       fin;
    logic [7:0] data;
  } item_t;

  typedef enum logic [2:0] {
    B_IDLE, B_LOAD, B_ROUND, B_ADD, B_PADZ, B_EMIT
  } bstate_t;

  localparam int BlockLen = 128;
  localparam int Rounds = 80;
  localparam logic [7:0] PadByte = 8'h80;

  function automatic word_t round_k(input logic [6:0] t);
    word_t k [0:79];
    k = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};
    return k[t];
  endfunction

  function automatic word_t init_value(input logic mode, input logic [2:0] i);
    word_t a [0:7];
    word_t b [0:7];
    a = '{64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
          64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
          64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};
    b = '{64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17,
          64'h152fecd8f70e5939, 64'h67332667ffc00b31, 64'h8eb44a8768581511,
          64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4};
    return mode ? b[i] : a[i];
  endfunction

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction
endpackage

>>> rtl/sha_front.sv
// Input queue that holds accepted beats until the compression side takes them.
module sha_front #(
  parameter int Depth = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  sha_pkg::item_t in_item,
  output logic           q_valid,
  input  logic           q_ready,
  output sha_pkg::item_t q_item
);
  localparam int Aw = $clog2(Depth);
  sha_pkg::item_t mem [Depth];
  logic [Aw-1:0] wr_ptr, rd_ptr;
  logic [Aw:0] count;
  logic push, pop;

  assign in_ready = count != Depth[Aw:0];
  assign q_valid  = count != '0;
  assign q_item   = mem[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop  = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == Aw'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == Aw'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (Aw+1)'(push) - (Aw+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_item;
  end
endmodule

>>> rtl/sha_back.sv
// Block packing, padding, 80-round compression and digest output.
module sha_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           mode,
  input  logic           q_valid,
  output logic           q_ready,
  input  sha_pkg::item_t q_item,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [63:0]    digest_word,
  output logic [2:0]     word_index,
  output logic           last_word,
  output logic           busy
);
  sha_pkg::bstate_t state, state_next;
  sha_pkg::word_t chain [8];
  sha_pkg::word_t wk [8];
  sha_pkg::word_t sched [16];
  sha_pkg::word_t blk [16];
  logic [6:0] fill;
  logic [6:0] waddr;
  logic [63:0] bit_total;
  logic msg_open;
  logic [6:0] rnd;
  logic [3:0] ld;
  logic [6:0] pz;
  logic final_blk, two_pass;
  logic [2:0] emit_idx;
  logic [63:0] wt, t1, t2, w2, w15, s0, s1, ldword;

  always_comb begin
    ldword = blk[ld];
    w2  = sched[4'(rnd - 7'd2)];
    w15 = sched[4'(rnd - 7'd15)];
    s1 = sha_pkg::rotr(w2, 19) ^ sha_pkg::rotr(w2, 61) ^ (w2 >> 6);
    s0 = sha_pkg::rotr(w15, 1) ^ sha_pkg::rotr(w15, 8) ^ (w15 >> 7);
    wt = (rnd < 7'd16) ? sched[rnd[3:0]] : s1 + sched[4'(rnd - 7'd7)] + s0 + sched[rnd[3:0]];
    t1 = wk[7] + (sha_pkg::rotr(wk[4], 14) ^ sha_pkg::rotr(wk[4], 18) ^ sha_pkg::rotr(wk[4], 41))
       + ((wk[4] & wk[5]) ^ (~wk[4] & wk[6])) + sha_pkg::round_k(rnd) + wt;
    t2 = (sha_pkg::rotr(wk[0], 28) ^ sha_pkg::rotr(wk[0], 34) ^ sha_pkg::rotr(wk[0], 39))
       + ((wk[0] & wk[1]) ^ (wk[0] & wk[2]) ^ (wk[1] & wk[2]));
  end

  assign waddr = msg_open ? fill : 7'd0;
  assign q_ready = state == sha_pkg::B_IDLE;
  assign out_valid = state == sha_pkg::B_EMIT;
  assign digest_word = chain[emit_idx];
  assign word_index = emit_idx;
  assign last_word = emit_idx == (mode ? 3'd5 : 3'd7);
  assign busy = state != sha_pkg::B_IDLE;

  always_comb begin
    state_next = state;
    case (state)
      sha_pkg::B_IDLE: begin
        if (q_valid) begin
          if (!q_item.fin) state_next = (fill == 7'd127) ? sha_pkg::B_LOAD : sha_pkg::B_IDLE;
          else state_next = (msg_open && fill == 7'd127) ? sha_pkg::B_LOAD : sha_pkg::B_PADZ;
        end
      end
      sha_pkg::B_PADZ: if (pz == 7'd127) state_next = sha_pkg::B_LOAD;
      sha_pkg::B_LOAD: if (ld == 4'd15) state_next = sha_pkg::B_ROUND;
      sha_pkg::B_ROUND: if (rnd == 7'(sha_pkg::Rounds - 1)) state_next = sha_pkg::B_ADD;
      sha_pkg::B_ADD: begin
        if (!final_blk) state_next = sha_pkg::B_IDLE;
        else if (two_pass) state_next = sha_pkg::B_PADZ;
        else state_next = sha_pkg::B_EMIT;
      end
      sha_pkg::B_EMIT: if (out_ready && last_word) state_next = sha_pkg::B_IDLE;
      default: state_next = sha_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= sha_pkg::B_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      msg_open <= 1'b0;
      fill <= '0;
      bit_total <= '0;
      final_blk <= 1'b0;
      two_pass <= 1'b0;
      emit_idx <= '0;
      for (int i = 0; i < 8; i++) chain[i] <= sha_pkg::init_value(1'b0, 3'(i));
    end else begin
      case (state)
        sha_pkg::B_IDLE: begin
          if (q_valid) begin
            if (!msg_open) for (int i = 0; i < 8; i++) chain[i] <= sha_pkg::init_value(mode, 3'(i));
            msg_open <= 1'b1;
            if (!q_item.fin) begin
              blk[waddr[6:3]][{~waddr[2:0], 3'd0} +: 8] <= q_item.data;
              fill <= msg_open ? fill + 7'd1 : 7'd1;
              bit_total <= (msg_open ? bit_total : 64'd0) + 64'd8;
              final_blk <= 1'b0;
              ld <= '0;
            end else begin
              blk[waddr[6:3]][{~waddr[2:0], 3'd0} +: 8] <= sha_pkg::PadByte;
              if (!msg_open) bit_total <= '0;
              pz <= (msg_open ? fill : 7'd0) + 7'd1;
              two_pass <= msg_open && fill > 7'(sha_pkg::BlockLen - 17);
              final_blk <= 1'b1;
              ld <= '0;
            end
          end
        end
        sha_pkg::B_PADZ: begin
          if (!two_pass && pz >= 7'd120) begin
            blk[pz[6:3]][{~pz[2:0], 3'd0} +: 8] <= bit_total[8'(8'd63 - {pz[2:0], 3'd0}) -: 8];
          end else begin
            blk[pz[6:3]][{~pz[2:0], 3'd0} +: 8] <= 8'h00;
          end
          pz <= pz + 7'd1;
        end
        sha_pkg::B_LOAD: begin
          sched[ld] <= ldword;
          ld <= ld + 4'd1;
          if (ld == 4'd15) begin
            rnd <= '0;
            for (int i = 0; i < 8; i++) wk[i] <= chain[i];
          end
        end
        sha_pkg::B_ROUND: begin
          if (rnd >= 7'd16) sched[rnd[3:0]] <= wt;
          wk[7] <= wk[6]; wk[6] <= wk[5]; wk[5] <= wk[4];
          wk[4] <= wk[3] + t1;
          wk[3] <= wk[2]; wk[2] <= wk[1]; wk[1] <= wk[0];
          wk[0] <= t1 + t2;
          rnd <= rnd + 7'd1;
        end
        sha_pkg::B_ADD: begin
          for (int i = 0; i < 8; i++) chain[i] <= chain[i] + wk[i];
          if (final_blk && two_pass) begin
            two_pass <= 1'b0;
            pz <= '0;
          end
          emit_idx <= '0;
        end
        sha_pkg::B_EMIT: begin
          if (out_ready) begin
            emit_idx <= emit_idx + 3'd1;
            if (last_word) begin
              msg_open <= 1'b0;
              fill <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule

>>> rtl/sha512_sha384_hash_engine.sv
// Top level of the SHA-512/SHA-384 hash engine.
//  channel | direction | beat
//  in      | in        | action, data_byte
//  out     | out       | digest_word, word_index, last_word
//  cfg     | in        | digest_mode
// Byte beats are taken only while the back end is idle; every 128th byte starts the
// block load and the rounds of the single round unit. A finish adds up to two padding
// passes plus compression, then one digest word per cycle while out_ready is high.
// Reset is synchronous and selects SHA-512. A stalled output holds the engine;
// the input queue keeps taking beats until it is full.
`include "assert_macros.svh"
module sha512_sha384_hash_engine #(
  parameter int QueueDepth = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        digest_mode
);
  logic mode, q_valid, q_ready, busy;
  sha_pkg::item_t in_item, q_item;

  assign in_item = '{fin: action, data: data_byte};
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) mode <= 1'b0;
    else if (cfg_valid) mode <= digest_mode;
  end

  sha_front #(.Depth(QueueDepth)) u_front (
    .clk, .rst, .in_valid, .in_ready, .in_item,
    .q_valid, .q_ready, .q_item
  );

  sha_back u_back (
    .clk, .rst, .mode, .q_valid, .q_ready, .q_item,
    .out_valid, .out_ready, .digest_word, .word_index, .last_word, .busy
  );

  `ASSERT_NEVER(a_pop_busy, clk, rst, q_ready && busy, "queue popped while busy")
  `ASSERT_CLK(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(word_index), "output dropped")
  `ASSERT_CLK(a_last_end, clk, rst, out_valid && out_ready && last_word |=> !out_valid, "emit past last")
endmodule

>>> tb/tb.sv
// Self-checking testbench for the SHA-512/SHA-384 engine: byte and finish beats, digest checks.
`timescale 1ns / 100ps
module tb;
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic action = 1'b0;
  logic [7:0] data_byte = 8'h00;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [63:0] digest_word;
  logic [2:0] word_index;
  logic last_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic digest_mode = 1'b0;

  typedef struct packed {
    logic       fin;
    logic [7:0] data;
  } beat_t;

  typedef struct packed {
    logic [63:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_beat_t;

  beat_t pending_beats[$];
  digest_beat_t digest_q[$];
  int errors = 0;
  bit quiet = 1'b0;
  bit pause_send = 1'b0;

  logic [63:0] hv[8];
  logic [7:0] blk[128];
  int fill = 0;
  logic [63:0] nbits = 0;
  bit open_msg = 1'b0;
  logic mode_now = 1'b0;

  sha512_sha384_hash_engine dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .action(action), .data_byte(data_byte),
    .out_valid(out_valid), .out_ready(out_ready), .digest_word(digest_word),
    .word_index(word_index), .last_word(last_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .digest_mode(digest_mode)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] ror(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  task automatic compress();
    logic [63:0] w[16];
    logic [63:0] v[8];
    logic [63:0] wt, t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) begin
      w[i] = '0;
      for (int b = 0; b < 8; b++) w[i] = {w[i][55:0], blk[i*8+b]};
    end
    v = hv;
    for (int t = 0; t < 80; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        s1 = ror(w[(t-2)&15], 19) ^ ror(w[(t-2)&15], 61) ^ (w[(t-2)&15] >> 6);
        s0 = ror(w[(t-15)&15], 1) ^ ror(w[(t-15)&15], 8) ^ (w[(t-15)&15] >> 7);
        wt = s1 + w[(t-7)&15] + s0 + w[t&15];
        w[t&15] = wt;
      end
      t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::round_k(t[6:0]) + wt;
      t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hv[i] += v[i];
  endtask

  task automatic predict_digest(input beat_t bt);
    int i;
    int n;
    digest_beat_t d;
    if (!open_msg) begin
      for (int k = 0; k < 8; k++) hv[k] = sha_pkg::init_value(mode_now, k[2:0]);
      fill = 0;
      nbits = 0;
      open_msg = 1'b1;
    end
    if (!bt.fin) begin
      blk[fill] = bt.data;
      fill = (fill + 1) % 128;
      nbits += 64'd8;
      if (fill == 0) compress();
    end else begin
      i = fill;
      blk[i++] = 8'h80;
      if (i > 112) begin
        while (i < 128) blk[i++] = 8'h00;
        compress();
        i = 0;
      end
      while (i < 120) blk[i++] = 8'h00;
      for (int k = 0; k < 8; k++) blk[120+k] = nbits[63-8*k -: 8];
      compress();
      n = mode_now ? 6 : 8;
      for (int k = 0; k < n; k++) begin
        d.word = hv[k];
        d.idx = k[2:0];
        d.last = (k == n - 1);
        digest_q.push_back(d);
      end
      open_msg = 1'b0;
      fill = 0;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_digest('{fin: action, data: data_byte});
      end
      if ((!in_valid || in_ready) ) begin
        if (pending_beats.size() > 0 && !pause_send && (quiet || $urandom_range(99) >= 37))
            begin
          in_valid <= 1'b1;
          {action, data_byte} <= pending_beats.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (digest_q.size() == 0) begin
          $error("unexpected digest beat %h", digest_word);
          errors++;
        end else begin
          digest_beat_t e;
          e = digest_q.pop_front();
          if (digest_word !== e.word) begin
            $error("digest_word expected %h actual %h", e.word, digest_word);
            errors++;
          end
          if (word_index !== e.idx) begin
            $error("word_index expected %0d actual %0d", e.idx, word_index);
            errors++;
          end
          if (last_word !== e.last) begin
            $error("last_word expected %0d actual %0d", e.last, last_word);
            errors++;
          end
        end
      end
      out_ready <= quiet || ($urandom_range(99) >= 37);
    end
  end

  task automatic drain();
    while (pending_beats.size() > 0 || in_valid || digest_q.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    @(posedge clk);
    cfg_valid <= 1'b1;
    digest_mode <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    mode_now = m;
  endtask

  task automatic add_message(input int len, input bit pattern);
    beat_t b;
    for (int k = 0; k < len; k++) begin
      b.fin = 1'b0;
      b.data = pattern ? ((k & 1) ? 8'hff : 8'h00) : 8'($urandom_range(255));
      pending_beats.push_back(b);
    end
    b.fin = 1'b1;
    b.data = 8'($urandom_range(255));
    pending_beats.push_back(b);
  endtask

  initial begin
    int lens[6];
    int total;
    int len;
    lens = '{0, 1, 111, 112, 128, 3};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    add_message(0, 1'b1);
    add_message(3, 1'b1);
    drain();
    write_mode(1'b1);
    add_message(0, 1'b1);
    add_message(20, 1'b1);
    drain();
    write_mode(1'b0);
    // Switch the mode while a message is open; word count follows the new mode.
    add_message(5, 1'b0);
    void'(pending_beats.pop_back());
    drain();
    write_mode(1'b1);
    pending_beats.push_back('{fin: 1'b1, data: 8'h00});
    drain();
    write_mode(1'b0);
    total = 0;
    for (int ph = 0; ph < 6; ph++) begin
      write_mode(ph[0]);
      quiet = (ph == 2);
      add_message(lens[ph], 1'b0);
      total += lens[ph] + 1;
      while (total < 400 * (ph + 1) / 6) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(260) : $urandom_range(20);
        add_message(len, 1'b0);
        total += len + 1;
      end
      if (ph == 3) begin
        while (pending_beats.size() > 0) @(posedge clk);
        pause_send = 1'b1;
        while (digest_q.size() > 0 || in_valid) @(posedge clk);
        repeat (1000) @(posedge clk);
        pause_send = 1'b0;
      end
      drain();
    end
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

>>> sim.f
+incdir+rtl
rtl/sha_pkg.sv
rtl/sha_front.sv
rtl/sha_back.sv
rtl/sha512_sha384_hash_engine.sv
tb/tb.sv
